FILE: design/ihex_pkg.sv
// Shared types and constants for the Intel HEX record parser.
// No dependencies; used by ihex_char_decode and intel_hex_record_parser_unit.
package ihex_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned INDEX_W   = 10;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned NIBBLE_W  = 4;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [CHAR_W-1:0]  CH_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0]  CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0]  CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0]  CH_LO_A   = 8'h61;
  localparam logic [CHAR_W-1:0]  CH_LO_F   = 8'h66;
  localparam logic [CHAR_W-1:0]  CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0]  CH_UP_F   = 8'h46;

  localparam logic [BYTE_W-1:0]  REC_DATA  = 8'h00;
  localparam logic [BYTE_W-1:0]  REC_EOF   = 8'h01;

  localparam logic [INDEX_W-1:0] INDEX_TOP = 10'd1023;

  typedef enum logic [KIND_W-1:0] {
    EV_WRITE  = 2'd0,
    EV_STATUS = 2'd1,
    EV_END    = 2'd2
  } ev_kind_t;

  typedef struct packed {
    logic                is_colon;
    logic                is_hex;
    logic [NIBBLE_W-1:0] digit;
  } char_class_t;

endpackage

FILE: design/ihex_char_decode.sv
// Character classifier: flags a colon and converts hex digits of either case.
// Depends on ihex_pkg.
module ihex_char_decode
  import ihex_pkg::*;
(
  input  logic [CHAR_W-1:0] char_code,
  output char_class_t       char_class
);

  logic [CHAR_W-1:0] off_num;
  logic [CHAR_W-1:0] off_lo;
  logic [CHAR_W-1:0] off_up;

  assign off_num = char_code - CH_ZERO;
  assign off_lo  = char_code - CH_LO_A;
  assign off_up  = char_code - CH_UP_A;

  always_comb begin
    char_class.is_colon = (char_code == CH_COLON);
    char_class.is_hex   = 1'b1;
    char_class.digit    = '0;
    priority if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
      char_class.digit = off_num[NIBBLE_W-1:0];
    end else if (char_code >= CH_LO_A && char_code <= CH_LO_F) begin
      char_class.digit = off_lo[NIBBLE_W-1:0] + 4'd10;
    end else if (char_code >= CH_UP_A && char_code <= CH_UP_F) begin
      char_class.digit = off_up[NIBBLE_W-1:0] + 4'd10;
    end else begin
      char_class.is_hex = 1'b0;
    end
  end

endmodule

FILE: design/intel_hex_record_parser_unit.sv
// Top level of the Intel HEX record parser: record state and result register.
// Depends on ihex_pkg and ihex_char_decode.

// Takes one ASCII character per transaction and emits data byte writes,
// per-record checksum status and an end-of-file event. Every character is
// handled in the cycle it is accepted, so the block sustains one character
// per clock; a result sits in a single output register, and a new character
// is taken whenever that register is empty or being drained in the same
// cycle. A colon reports the previous record's checksum status; after the
// end-of-file record the block drops all input until reset.
module intel_hex_record_parser_unit
  import ihex_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [CHAR_W-1:0]     in_tdata,   // [7:0] char_code
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [15:0] write_address, [23:16] write_data,
                                            // [24] checksum_good, [31:25] zero
  output logic [KIND_W-1:0]     out_tuser   // [1:0] event_kind
);

  char_class_t        cc;
  logic               accept;

  logic [INDEX_W-1:0] char_index_r, char_index_nxt;
  logic [BYTE_W-1:0]  byte_value_r, byte_value_nxt;
  logic [BYTE_W-1:0]  remaining_r, remaining_nxt;
  logic [ADDR_W-1:0]  load_addr_r, load_addr_nxt;
  logic [BYTE_W-1:0]  rec_kind_r, rec_kind_nxt;
  logic [BYTE_W-1:0]  byte_sum_r, byte_sum_nxt;
  logic               record_open_r, record_open_nxt;
  logic               sum_matched_r, sum_matched_nxt;
  logic               finished_r, finished_nxt;

  logic               res_valid;
  ev_kind_t           res_kind;
  logic [ADDR_W-1:0]  res_addr;
  logic [BYTE_W-1:0]  res_data;
  logic               res_good;

  logic               out_valid_r;
  ev_kind_t           out_kind_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [BYTE_W-1:0]  out_data_r;
  logic               out_good_r;

  logic [BYTE_W-1:0]  full_byte;
  logic [INDEX_W-1:0] index_adv;

  ihex_char_decode u_decode (
    .char_code  (in_tdata),
    .char_class (cc)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign full_byte = {byte_value_r[NIBBLE_W-1:0], cc.digit};
  // Past the top the index toggles between its last two values to keep pairing.
  assign index_adv = (char_index_r == INDEX_TOP) ? (INDEX_TOP - 10'd1) : (char_index_r + 10'd1);

  always_comb begin
    char_index_nxt  = char_index_r;
    byte_value_nxt  = byte_value_r;
    remaining_nxt   = remaining_r;
    load_addr_nxt   = load_addr_r;
    rec_kind_nxt    = rec_kind_r;
    byte_sum_nxt    = byte_sum_r;
    record_open_nxt = record_open_r;
    sum_matched_nxt = sum_matched_r;
    finished_nxt    = finished_r;
    res_valid       = 1'b0;
    res_kind        = EV_WRITE;
    res_addr        = '0;
    res_data        = '0;
    res_good        = 1'b0;

    if (accept && !finished_r) begin
      if (cc.is_colon) begin
        res_valid       = record_open_r;
        res_kind        = EV_STATUS;
        res_good        = sum_matched_r;
        remaining_nxt   = '0;
        load_addr_nxt   = '0;
        byte_sum_nxt    = '0;
        char_index_nxt  = '0;
        sum_matched_nxt = 1'b0;
        record_open_nxt = 1'b1;
      end else if (cc.is_hex && record_open_r) begin
        if (!char_index_r[0]) begin
          byte_value_nxt = {{(BYTE_W-NIBBLE_W){1'b0}}, cc.digit};
          char_index_nxt = index_adv;
        end else begin
          byte_value_nxt = full_byte;
          char_index_nxt = index_adv;
          byte_sum_nxt   = byte_sum_r + full_byte;
          priority if (char_index_r < 10'd2) begin
            remaining_nxt = full_byte;
          end else if (char_index_r < 10'd6) begin
            load_addr_nxt = {load_addr_r[ADDR_W-BYTE_W-1:0], full_byte};
          end else if (char_index_r < 10'd8) begin
            rec_kind_nxt = full_byte;
          end else if (remaining_r != '0) begin
            if (rec_kind_r == REC_DATA) begin
              res_valid     = 1'b1;
              res_kind      = EV_WRITE;
              res_addr      = load_addr_r;
              res_data      = full_byte;
              load_addr_nxt = load_addr_r + 16'd1;
            end
            remaining_nxt = remaining_r - 8'd1;
          end else begin
            // Checksum byte, or a surplus byte that is checked again.
            if (full_byte == (8'd0 - byte_sum_r)) begin
              sum_matched_nxt = 1'b1;
            end
            if (rec_kind_r == REC_EOF) begin
              res_valid      = 1'b1;
              res_kind       = EV_END;
              res_good       = sum_matched_nxt;
              finished_nxt   = 1'b1;
              char_index_nxt = char_index_r;
              byte_sum_nxt   = byte_sum_r;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_index_r  <= '0;
      byte_value_r  <= '0;
      remaining_r   <= '0;
      load_addr_r   <= '0;
      rec_kind_r    <= REC_DATA;
      byte_sum_r    <= '0;
      record_open_r <= 1'b0;
      sum_matched_r <= 1'b0;
      finished_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      char_index_r  <= char_index_nxt;
      byte_value_r  <= byte_value_nxt;
      remaining_r   <= remaining_nxt;
      load_addr_r   <= load_addr_nxt;
      rec_kind_r    <= rec_kind_nxt;
      byte_sum_r    <= byte_sum_nxt;
      record_open_r <= record_open_nxt;
      sum_matched_r <= sum_matched_nxt;
      finished_r    <= finished_nxt;
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_kind_r <= res_kind;
      out_addr_r <= res_addr;
      out_data_r <= res_data;
      out_good_r <= res_good;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {{(OUT_DATA_W-ADDR_W-BYTE_W-1){1'b0}}, out_good_r, out_data_r, out_addr_r};

  a_end_event: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(finished_r) |-> out_valid_r && (out_kind_r == EV_END))
    else $error("end of file did not produce an end event");

  a_nonwrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r != EV_WRITE) |-> (out_addr_r == '0) && (out_data_r == '0))
    else $error("status or end event carries address or data");

  a_write_no_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == EV_WRITE) |-> !out_good_r)
    else $error("write event carries a checksum flag");

  a_closed_index: assert property (@(posedge clk) disable iff (!rst_n)
    !record_open_r |-> (char_index_r == '0) && !finished_r)
    else $error("digit index moved outside an open record");

endmodule

FILE: dv/intel_hex_record_parser_unit_test.sv
// Self-checking testbench for intel_hex_record_parser_unit: streams Intel HEX text into
// the parser, mirrors its record state in a scoreboard and checks every emitted event.
// Depends on ihex_pkg and the RTL of intel_hex_record_parser_unit.

module intel_hex_record_parser_unit_test
  import ihex_pkg::*;
();

  typedef struct {
    ev_kind_t          kind;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic              good;
  } hex_event_t;

  class hex_event_checker;
    logic [INDEX_W-1:0] digit_pos;
    logic [BYTE_W-1:0]  held_byte;
    logic [BYTE_W-1:0]  bytes_left;
    logic [ADDR_W-1:0]  next_addr;
    logic [BYTE_W-1:0]  rec_type;
    logic [BYTE_W-1:0]  running_sum;
    bit                 in_record;
    bit                 sum_ok;
    bit                 eof_seen;
    hex_event_t         pending_events[$];
    int unsigned        mismatches;
    int unsigned        live_chars;

    function new();
      digit_pos   = '0;
      held_byte   = '0;
      bytes_left  = '0;
      next_addr   = '0;
      rec_type    = REC_DATA;
      running_sum = '0;
      in_record   = 1'b0;
      sum_ok      = 1'b0;
      eof_seen    = 1'b0;
      mismatches  = 0;
      live_chars  = 0;
    endfunction

    function void add_event(ev_kind_t kind, logic [ADDR_W-1:0] addr,
                            logic [BYTE_W-1:0] data, logic good);
      hex_event_t ev;
      ev.kind = kind;
      ev.addr = addr;
      ev.data = data;
      ev.good = good;
      pending_events.push_back(ev);
    endfunction

    // Past the top the position toggles between the last two values to keep digit pairing.
    function void step_index();
      if (digit_pos >= INDEX_TOP) digit_pos = INDEX_TOP - 1'b1;
      else digit_pos = digit_pos + 1'b1;
    endfunction

    // Mirrors the parser for one accepted character and queues the event it causes.
    function void note_char(logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0]   offs;
      logic [BYTE_W-1:0]   b;
      logic [BYTE_W-1:0]   want_sum;
      bit                  is_hex;
      if (eof_seen) return;
      if (c == CH_COLON) begin
        if (in_record) add_event(EV_STATUS, '0, '0, sum_ok);
        bytes_left  = '0;
        next_addr   = '0;
        running_sum = '0;
        digit_pos   = '0;
        sum_ok      = 1'b0;
        in_record   = 1'b1;
        live_chars++;
        return;
      end
      is_hex = 1'b1;
      offs   = '0;
      if (c >= CH_ZERO && c <= CH_NINE) offs = c - CH_ZERO;
      else if (c >= CH_LO_A && c <= CH_LO_F) offs = c - CH_LO_A + 8'd10;
      else if (c >= CH_UP_A && c <= CH_UP_F) offs = c - CH_UP_A + 8'd10;
      else is_hex = 1'b0;
      if (!is_hex || !in_record) return;
      live_chars++;
      if (!digit_pos[0]) begin
        held_byte = {4'h0, offs[3:0]};
        step_index();
        return;
      end
      b = {held_byte[3:0], offs[3:0]};
      held_byte = b;
      if (digit_pos < 2) begin
        bytes_left = b;
      end else if (digit_pos < 6) begin
        next_addr = {next_addr[7:0], b};
      end else if (digit_pos < 8) begin
        rec_type = b;
      end else if (bytes_left != 0) begin
        if (rec_type == REC_DATA) begin
          add_event(EV_WRITE, next_addr, b, 1'b0);
          next_addr = next_addr + 1'b1;
        end
        bytes_left = bytes_left - 1'b1;
      end else begin
        want_sum = ~running_sum + 1'b1;
        if (b == want_sum) sum_ok = 1'b1;
        if (rec_type == REC_EOF) begin
          add_event(EV_END, '0, '0, sum_ok);
          eof_seen = 1'b1;
          return;
        end
      end
      step_index();
      running_sum = running_sum + b;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_event(logic [KIND_W-1:0] kind, logic [OUT_DATA_W-1:0] word);
      hex_event_t want;
      if (pending_events.size() == 0) begin
        $error("event with none pending: event_kind %0d, tdata 0x%h", kind, word);
        mismatches++;
        return;
      end
      want = pending_events.pop_front();
      compare_field("event_kind", want.kind, kind);
      compare_field("write_address", want.addr, word[15:0]);
      compare_field("write_data", want.data, word[23:16]);
      compare_field("checksum_good", want.good, word[24]);
      compare_field("tdata padding", '0, word[31:25]);
    endfunction
  endclass

  localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [CHAR_W-1:0]     in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;

  int unsigned      tx_idle_pct = 0;
  int unsigned      rx_idle_pct = 0;
  hex_event_checker events_sb = new();

  intel_hex_record_parser_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check each completed transaction, then pick the next ready value.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) events_sb.check_event(out_tuser, out_tdata);
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [CHAR_W-1:0] hex_char(logic [NIBBLE_W-1:0] nib);
    if (nib < 10) return CH_ZERO + nib;
    return ($urandom_range(1) ? CH_LO_A : CH_UP_A) + nib - 8'd10;
  endfunction

  function automatic logic [CHAR_W-1:0] noise_char();
    logic [CHAR_W-1:0] c;
    do
      c = 8'($urandom_range(255));
    while (c == CH_COLON || (c >= CH_ZERO && c <= CH_NINE) ||
           (c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F));
    return c;
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] c);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    events_sb.note_char(c);
  endtask

  // Sends one record; a nonzero skew spoils the checksum, trailing bytes follow it,
  // and a nonnegative cut stops the record after that many hex digits.
  task automatic send_record(input int unsigned len, input logic [ADDR_W-1:0] addr,
                             input logic [BYTE_W-1:0] kind, input logic [BYTE_W-1:0] skew,
                             input int unsigned extra, input int cut);
    logic [BYTE_W-1:0] rec[$];
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] fix;
    logic [BYTE_W-1:0] b;
    int                digits;
    int                i;
    rec.push_back(len[7:0]);
    rec.push_back(addr[15:8]);
    rec.push_back(addr[7:0]);
    rec.push_back(kind);
    for (i = 0; i < len; i++) rec.push_back(8'($urandom_range(255)));
    sum = '0;
    foreach (rec[k]) sum = sum + rec[k];
    fix = ~sum + 1'b1 + skew;
    rec.push_back(fix);
    sum = sum + fix;
    // Trailing bytes are compared as checksums again; about half are made to match.
    for (i = 0; i < extra; i++) begin
      fix = ~sum + 1'b1;
      b = $urandom_range(1) ? fix : 8'($urandom_range(255));
      rec.push_back(b);
      sum = sum + b;
    end
    digits = 2 * rec.size();
    if (cut >= 0 && cut < digits) digits = cut;
    send_char(CH_COLON);
    for (i = 0; i < digits; i++) begin
      if ($urandom_range(99) < 4) send_char(noise_char());
      b = rec[i / 2];
      send_char(hex_char(i[0] ? b[3:0] : b[7:4]));
    end
    if ($urandom_range(3) == 0) begin
      send_char(CH_CR);
      send_char(CH_LF);
    end
  endtask

  task automatic random_record();
    int unsigned       pick;
    int unsigned       len;
    int unsigned       extra;
    int                cut;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] kind;
    logic [BYTE_W-1:0] skew;
    pick = $urandom_range(99);
    if (pick < 70) len = $urandom_range(8);
    else if (pick < 96) len = $urandom_range(32, 9);
    else len = $urandom_range(255, 33);
    addr = 16'($urandom_range(65535));
    // Start close to the top now and then so the write address wraps.
    if ($urandom_range(4) == 0) addr[15:5] = '1;
    kind = REC_DATA;
    if ($urandom_range(4) == 0) kind = 8'($urandom_range(255, 2));
    skew  = ($urandom_range(6) == 0) ? 8'($urandom_range(255, 1)) : '0;
    extra = ($urandom_range(6) == 0) ? $urandom_range(3, 1) : 0;
    cut   = ($urandom_range(9) == 0) ? int'($urandom_range(2 * (len + 5 + extra) - 1)) : -1;
    send_record(len, addr, kind, skew, extra, cut);
  endtask

  task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                           input int unsigned count);
    int unsigned goal;
    int unsigned pick;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    goal = events_sb.live_chars + count;
    while (events_sb.live_chars < goal) begin
      pick = $urandom_range(99);
      if (pick < 88) random_record();
      else if (pick < 96) repeat ($urandom_range(4, 1)) send_char(noise_char());
      else repeat ($urandom_range(3, 1)) send_char(hex_char(4'($urandom_range(15))));
    end
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (events_sb.pending_events.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 9;
    rx_idle_pct = 72;
    // Digits and code extremes before the first colon must be dropped.
    send_char(CH_ZERO);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_LF);
    // Two writes that wrap from the top address to zero.
    send_record(2, 16'hFFFF, REC_DATA, 8'h00, 0, -1);
    // Non-data type with a bad checksum that a trailing byte may still match.
    send_record(1, 16'h1234, 8'h04, 8'h3C, 1, -1);
    run_phase(9, 72, 90);
    hold_until_drained();
    run_phase(72, 9, 90);
    // Long enough to drive the digit position to its ceiling and hold it there.
    send_record(255, 16'($urandom_range(65535)), REC_DATA, 8'h00, 262, -1);
    run_phase(0, 0, 90);
    send_record($urandom_range(3), '0, REC_EOF, ($urandom_range(1) ? 8'h00 : 8'h5A), 0, -1);
    // Everything after the end-of-file record is dropped.
    send_char(CH_COLON);
    repeat (8) send_char(hex_char(4'($urandom_range(15))));
    send_char(CH_COLON);
    send_char(noise_char());
    hold_until_drained();
    repeat (16) @(posedge clk);
    if (events_sb.mismatches == 0 && events_sb.pending_events.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
